/* rtl/sha_pkg.sv */
// Shared types and constants for the SHA-256 stream hasher.
// Used by sha_blkbuf, sha_core and sha256_stream_hasher; no dependencies.
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_vars;
        logic push;
        logic round;
        logic add;
        logic restart;
    } core_ctl_t;

    typedef struct packed {
        logic pad;
        logic len_only;
    } pad_ctl_t;

    localparam int unsigned ROUNDS = 64;

    localparam logic [31:0] K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_LIMIT = 6'd56;

endpackage

/* rtl/sha_blkbuf.sv */
// Block buffer: packs message bytes into a 16-word synchronous memory, keeps
// the fill count and bit count, and produces padded words. Uses sha_pkg.
module sha_blkbuf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_we,
    input  logic [7:0]        byte_in,
    input  logic              clear,
    input  logic [3:0]        rd_idx,
    input  sha_pkg::pad_ctl_t pad_ctl,
    output logic [31:0]       word_out,
    output logic [5:0]        fill,
    output logic              fill_ge56
);

    logic [31:0] mem [16];
    logic [31:0] mem_q_reg;
    logic [3:0]  idx_reg;
    logic [23:0] acc_reg;
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [31:0] partial;

    always_ff @(posedge aclk) begin
        if (byte_we && fill_reg[1:0] == 2'd3) begin
            mem[fill_reg[5:2]] <= {acc_reg, byte_in};
        end
        mem_q_reg <= mem[rd_idx];
        idx_reg   <= rd_idx;
        if (byte_we) begin
            acc_reg <= {acc_reg[15:0], byte_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            bits_reg <= '0;
        end else if (clear) begin
            fill_reg <= '0;
            bits_reg <= '0;
        end else if (byte_we) begin
            fill_reg <= fill_reg + 6'd1;
            bits_reg <= bits_reg + 64'd8;
        end
    end

    always_comb begin
        unique case (fill_reg[1:0])
            2'd0: partial = {sha_pkg::PAD_BYTE, 24'd0};
            2'd1: partial = {acc_reg[7:0], sha_pkg::PAD_BYTE, 16'd0};
            2'd2: partial = {acc_reg[15:0], sha_pkg::PAD_BYTE, 8'd0};
            default: partial = {acc_reg[23:0], sha_pkg::PAD_BYTE};
        endcase
    end

    always_comb begin
        priority if (pad_ctl.len_only) begin
            if (idx_reg == 4'd14) word_out = bits_reg[63:32];
            else if (idx_reg == 4'd15) word_out = bits_reg[31:0];
            else word_out = '0;
        end else if (!pad_ctl.pad) begin
            word_out = mem_q_reg;
        end else if (idx_reg < fill_reg[5:2]) begin
            word_out = mem_q_reg;
        end else if (idx_reg == fill_reg[5:2]) begin
            word_out = partial;
        end else if (!fill_ge56 && idx_reg == 4'd14) begin
            word_out = bits_reg[63:32];
        end else if (!fill_ge56 && idx_reg == 4'd15) begin
            word_out = bits_reg[31:0];
        end else begin
            word_out = '0;
        end
    end

    assign fill      = fill_reg;
    assign fill_ge56 = fill_reg >= sha_pkg::LEN_LIMIT;

endmodule

/* rtl/sha_core.sv */
// Compression core: 16-word schedule window, working variables and hash
// words; one round per cycle. Uses sha_pkg.
module sha_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  sha_pkg::core_ctl_t ctl,
    input  logic [31:0]        word_in,
    input  logic [5:0]         round_idx,
    input  logic [2:0]         out_idx,
    output logic [31:0]        hash_out
);

    logic [31:0] win_reg  [16];
    logic [31:0] v_reg    [8];
    logic [31:0] hash_reg [8];
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] ep0;
    logic [31:0] ep1;
    logic [31:0] ch;
    logic [31:0] maj;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    always_comb begin
        s0    = rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3);
        s1    = rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10);
        w_new = s1 + win_reg[9] + s0 + win_reg[0];
        ep1   = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ep0   = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + ep1 + ch + sha_pkg::K_TABLE[round_idx] + win_reg[0];
        t2    = ep0 + maj;
    end

    always_ff @(posedge aclk) begin
        if (ctl.push || ctl.round) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= ctl.push ? word_in : w_new;
        end
        if (ctl.load_vars) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= hash_reg[i];
            end
        end else if (ctl.round) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.restart) begin
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= sha_pkg::H_INIT[i];
            end
        end else if (ctl.add) begin
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= hash_reg[i] + v_reg[i];
            end
        end
    end

    assign hash_out = hash_reg[out_idx];

endmodule

/* rtl/sha256_stream_hasher.sv */
// SHA-256 stream hasher top level: control sequencer and stream ports.
// Instantiates sha_blkbuf and sha_core; uses sha_pkg.
//
// Takes one message byte per beat; a beat with tlast ends the message and
// the block then returns the eight digest words, word 0 first, with tlast on
// word 7, and starts over on the initial hash. A beat that fills a 64-byte
// block, or that has tlast, holds s_tready low for a compression: the block
// words stream out of the buffer memory, 64 rounds run on the single round
// unit, and the result is added into the hash. A finish compresses one
// padded block, or two when 56 or more bytes of the last block are filled,
// then emits the eight words, one per cycle while m_tready is high.
module sha256_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // byte_present
    input  logic        s_tlast,   // finish
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word
    output logic [2:0]  m_tuser,   // word_index
    output logic        m_tlast    // last_word
);

    sha_pkg::state_t    state_reg, state_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               pad_reg, pad_next;
    logic               len_reg, len_next;
    logic               pend_reg, pend_next;
    logic [2:0]         oidx_reg, oidx_next;
    sha_pkg::core_ctl_t core_ctl;
    sha_pkg::pad_ctl_t  pad_ctl;
    logic               s_beat;
    logic               m_beat;
    logic               byte_we;
    logic               clear;
    logic [31:0]        word;
    logic [5:0]         fill;
    logic               fill_ge56;

    assign s_beat = s_tvalid && s_tready;
    assign m_beat = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha_pkg::ST_IDLE;
            cnt_reg   <= '0;
            pad_reg   <= 1'b0;
            len_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            oidx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pad_reg   <= pad_next;
            len_reg   <= len_next;
            pend_reg  <= pend_next;
            oidx_reg  <= oidx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pad_next   = pad_reg;
        len_next   = len_reg;
        pend_next  = pend_reg;
        oidx_next  = oidx_reg;
        unique case (state_reg)
            sha_pkg::ST_IDLE: begin
                cnt_next = '0;
                if (s_beat) begin
                    if (s_tuser && fill == 6'd63) begin
                        state_next = sha_pkg::ST_LOAD;
                        pad_next   = 1'b0;
                        len_next   = 1'b0;
                        pend_next  = s_tlast;
                    end else if (s_tlast) begin
                        state_next = sha_pkg::ST_LOAD;
                        pad_next   = 1'b1;
                        len_next   = 1'b0;
                        pend_next  = 1'b0;
                    end
                end
            end
            sha_pkg::ST_LOAD: begin
                if (cnt_reg == 6'd16) begin
                    state_next = sha_pkg::ST_ROUND;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            sha_pkg::ST_ROUND: begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    state_next = sha_pkg::ST_ADD;
                end
            end
            sha_pkg::ST_ADD: begin
                cnt_next = '0;
                priority if (!pad_reg && pend_reg) begin
                    state_next = sha_pkg::ST_LOAD;
                    pad_next   = 1'b1;
                    pend_next  = 1'b0;
                end else if (!pad_reg) begin
                    state_next = sha_pkg::ST_IDLE;
                end else if (!len_reg && fill_ge56) begin
                    state_next = sha_pkg::ST_LOAD;
                    len_next   = 1'b1;
                end else begin
                    state_next = sha_pkg::ST_EMIT;
                    oidx_next  = '0;
                end
            end
            sha_pkg::ST_EMIT: begin
                if (m_beat) begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        state_next = sha_pkg::ST_IDLE;
                        pad_next   = 1'b0;
                        len_next   = 1'b0;
                    end
                end
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready          = state_reg == sha_pkg::ST_IDLE;
        m_tvalid          = state_reg == sha_pkg::ST_EMIT;
        byte_we           = s_beat && s_tuser;
        clear             = m_beat && oidx_reg == 3'd7;
        core_ctl.load_vars = state_reg == sha_pkg::ST_LOAD && cnt_reg == 6'd0;
        core_ctl.push     = state_reg == sha_pkg::ST_LOAD && cnt_reg != 6'd0;
        core_ctl.round    = state_reg == sha_pkg::ST_ROUND;
        core_ctl.add      = state_reg == sha_pkg::ST_ADD;
        core_ctl.restart  = clear;
        pad_ctl.pad       = pad_reg;
        pad_ctl.len_only  = len_reg;
        m_tuser           = oidx_reg;
        m_tlast           = oidx_reg == 3'd7;
    end

    sha_blkbuf u_blkbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_we   (byte_we),
        .byte_in   (s_tdata),
        .clear     (clear),
        .rd_idx    (cnt_reg[3:0]),
        .pad_ctl   (pad_ctl),
        .word_out  (word),
        .fill      (fill),
        .fill_ge56 (fill_ge56)
    );

    sha_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (core_ctl),
        .word_in   (word),
        .round_idx (cnt_reg),
        .out_idx   (oidx_reg),
        .hash_out  (m_tdata)
    );

`ifndef SYNTHESIS
    a_sides_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output sides active together");

    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sha_pkg::ST_ROUND && cnt_reg == 6'd63) |=>
        state_reg == sha_pkg::ST_ADD)
        else $error("round count did not end in add");

    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_beat && m_tlast) |=> (s_tready && fill == 6'd0))
        else $error("digest end did not return to idle");

    a_load_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sha_pkg::ST_LOAD && len_reg) |-> (pad_reg && fill_ge56))
        else $error("length-only block without overflowing pad");
`endif

endmodule

/* bench/sha256_stream_hasher_tb.sv */
// Self-checking bench for sha256_stream_hasher: byte messages in, digest words out.
// Keeps its own SHA-256 digest calculator and compares every result beat with it.
// Depends on sha_pkg (initial hash values, round constants, pad byte, length limit) and the RTL top level.
module sha256_stream_hasher_tb;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 200;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       fin;
        logic       hold;
    } msg_beat_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    msg_beat_t    pending_beats[$];
    digest_beat_t digest_due[$];

    logic [31:0] chain[8];
    logic [7:0]  blk[64];
    int          fill;
    logic [63:0] bit_len;

    int errors = 0;
    int cycle_no = 0;
    int quiet_cycles = 0;
    int messages_done = 0;
    int words_checked = 0;

    sha256_stream_hasher dut (.*);

    always #2 aclk = ~aclk;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress_blk();
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        for (int i = 0; i < 8; i++)
            v[i] = chain[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::K_TABLE[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] += v[i];
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++)
            chain[i] = sha_pkg::H_INIT[i];
        fill = 0;
        bit_len = '0;
    endfunction

    function automatic void absorb_beat(input msg_beat_t b);
        if (b.present) begin
            blk[fill] = b.data;
            fill = (fill + 1) % 64;
            bit_len += 64'd8;
            if (fill == 0)
                compress_blk();
        end
        if (!b.fin)
            return;
        blk[fill] = sha_pkg::PAD_BYTE;
        for (int i = fill + 1; i < 64; i++)
            blk[i] = '0;
        if (fill >= sha_pkg::LEN_LIMIT) begin
            compress_blk();
            for (int i = 0; i < 64; i++)
                blk[i] = '0;
        end
        for (int i = 0; i < 8; i++)
            blk[56+i] = bit_len[63-8*i -: 8];
        compress_blk();
        for (int i = 0; i < 8; i++)
            digest_due.push_back('{word: chain[i], index: 3'(i), last: (i == 7)});
        restart_hash();
    endfunction

    function automatic bit idle_now();
        if (cycle_no > 1200 && cycle_no < 2400)
            return 1'b0;
        return $urandom_range(0, 99) < 15;
    endfunction

    // Sender: present the head of the pending queue, honour drain holds.
    always @(posedge aclk) begin
        logic go;
        cycle_no <= cycle_no + 1;
        if (cycle_no == 6)
            aresetn <= 1'b1;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                absorb_beat(pending_beats.pop_front());
                if (s_tlast)
                    messages_done <= messages_done + 1;
            end
            go = 1'b0;
            if (pending_beats.size() > 0) begin
                if (s_tvalid && !(s_tvalid && s_tready))
                    go = 1'b1;
                else if (!(pending_beats[0].hold && digest_due.size() > 0) && !idle_now())
                    go = 1'b1;
            end
            s_tvalid <= go;
            if (go) begin
                s_tdata <= pending_beats[0].data;
                s_tuser <= pending_beats[0].present;
                s_tlast <= pending_beats[0].fin;
            end
        end
    end

    // Receiver: random back-pressure, check every digest beat.
    always @(posedge aclk) begin
        digest_beat_t exp_b;
        if (aresetn) begin
            m_tready <= !idle_now();
            if (m_tvalid && m_tready) begin
                if (digest_due.size() == 0) begin
                    $display("%0t: unexpected digest beat exp none got %h/%0d/%b",
                             $time, m_tdata, m_tuser, m_tlast);
                    errors <= errors + 1;
                end else begin
                    exp_b = digest_due.pop_front();
                    words_checked <= words_checked + 1;
                    if (m_tdata !== exp_b.word || m_tuser !== exp_b.index
                        || m_tlast !== exp_b.last) begin
                        $display("%0t: digest mismatch exp %h/%0d/%b got %h/%0d/%b",
                                 $time, exp_b.word, exp_b.index, exp_b.last,
                                 m_tdata, m_tuser, m_tlast);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no beat on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d digest beats outstanding", $time, digest_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void add_beat(input logic [7:0] d, input logic p, input logic f,
                                     input logic h = 1'b0);
        pending_beats.push_back('{data: d, present: p, fin: f, hold: h});
    endfunction

    function automatic int add_message(input int len, input bit hold_first);
        bit fused;
        int n;
        fused = (len > 0) && $urandom_range(0, 1);
        n = 0;
        for (int i = 0; i < len; i++) begin
            add_beat(8'($urandom), 1'b1, fused && (i == len - 1), hold_first && i == 0);
            n++;
            if ($urandom_range(0, 19) == 0) begin
                add_beat(8'($urandom), 1'b0, 1'b0);
                n++;
            end
        end
        if (!fused) begin
            add_beat(8'($urandom), 1'b0, 1'b1, hold_first && len == 0);
            n++;
        end
        return n;
    endfunction

    initial begin
        int items;
        int len;
        restart_hash();
        for (int i = 0; i < 64; i++)
            blk[i] = '0;
        // empty message, lone no-op beat, then fused-finish, separate-finish and one-byte messages
        add_beat(8'hff, 1'b0, 1'b1);
        add_beat(8'h5a, 1'b0, 1'b0);
        add_beat(8'h00, 1'b1, 1'b0);
        add_beat(8'hff, 1'b1, 1'b0);
        add_beat(8'h61, 1'b1, 1'b1);
        add_beat(8'h62, 1'b1, 1'b0);
        add_beat(8'h00, 1'b0, 1'b1);
        add_beat(8'h80, 1'b1, 1'b1);
        items = 8;
        // lengths around the padding boundary and past one block, one drain hold
        items += add_message(55, 1'b0);
        items += add_message(56, 1'b1);
        items += add_message(63, 1'b0);
        items += add_message(64, 1'b0);
        items += add_message(119, 1'b0);
        items += add_message(120, 1'b0);
        while (items < 420) begin
            if ($urandom_range(0, 9) < 8)
                len = $urandom_range(0, 20);
            else
                len = $urandom_range(52, 130);
            items += add_message(len, $urandom_range(0, 29) == 0);
        end
        wait (aresetn);
        while (pending_beats.size() > 0 || digest_due.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Hashed %0d messages from %0d input beats, %0d digest words checked.",
                 messages_done, items, words_checked);
        $display("Covered empty, fused-finish, 55/56/63/64/119/120-byte and multi-block messages.");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
